// ===== rtl/core/bps_pkg.sv =====
// shared types, constants and the blend function for the bilinear pixel sampler
// no dependencies
package bps_pkg;

  localparam int COORD_W   = 16;
  localparam int FRAC_BITS = 8;
  localparam int INT_W     = COORD_W - FRAC_BITS;
  localparam int DIM_W     = 9;
  localparam int CHAN_W    = 8;
  localparam int PIX_W     = 3 * CHAN_W;
  localparam int ADDR_W    = 16;
  localparam int DEPTH     = 1 << ADDR_W;
  localparam int NBANK     = 4;
  localparam int CFG_IDX_W = 2;
  localparam logic [DIM_W-1:0] MAX_WIDTH  = DIM_W'(256);
  localparam logic [DIM_W-1:0] MAX_HEIGHT = DIM_W'(256);
  localparam logic [FRAC_BITS:0] FRAC_ONE = (FRAC_BITS+1)'(1 << FRAC_BITS);

  localparam logic CMD_WRITE  = 1'b0;
  localparam logic CMD_SAMPLE = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = CFG_IDX_W'(1);

  // bank order: top-left, top-right, bottom-left, bottom-right
  localparam int TL = 0;
  localparam int TR = 1;
  localparam int BL = 2;
  localparam int BR = 3;

  typedef struct packed {
    logic                cmd;
    logic [COORD_W-1:0]  x_pos;
    logic [COORD_W-1:0]  y_pos;
    logic [PIX_W-1:0]    pixel_in;
  } req_t;

  typedef struct packed {
    logic [CHAN_W-1:0] red_out;
    logic [CHAN_W-1:0] green_out;
    logic [CHAN_W-1:0] blue_out;
    logic              ok;
  } res_t;

  // addressed request on its way into the store
  typedef struct packed {
    logic                          valid;
    logic                          cmd;
    logic                          landed;
    logic [FRAC_BITS-1:0]          fx;
    logic [FRAC_BITS-1:0]          fy;
    logic [PIX_W-1:0]              color;
    logic [NBANK-1:0][ADDR_W-1:0]  addr;
  } mem_ctl_t;

  // request leaving the store alongside the read data
  typedef struct packed {
    logic                 valid;
    logic                 cmd;
    logic                 landed;
    logic [FRAC_BITS-1:0] fx;
    logic [FRAC_BITS-1:0] fy;
  } blend_ctl_t;

  function automatic logic [CHAN_W-1:0] lerp(input logic [CHAN_W-1:0] p0,
                                             input logic [CHAN_W-1:0] p1,
                                             input logic [FRAC_BITS-1:0] f);
    logic [FRAC_BITS:0]              w0;
    logic [CHAN_W+FRAC_BITS:0]       a;
    logic [CHAN_W+FRAC_BITS:0]       b;
    logic [CHAN_W+FRAC_BITS:0]       s;
    w0 = FRAC_ONE - {1'b0, f};
    a  = (CHAN_W+FRAC_BITS+1)'(p0 * w0);
    b  = (CHAN_W+FRAC_BITS+1)'(p1 * f);
    s  = a + b;
    return s[FRAC_BITS +: CHAN_W];
  endfunction

endpackage

// ===== rtl/core/bilinear_pixel_sampler.sv =====
// bilinear pixel sampler top level: a request enters every cycle
// done rises once the accepted request has passed the clamp, address, store read,
// horizontal blend and vertical blend registers, in that order
// throughput one request per cycle, busy stays low
// reset clears valid bits and sets width and height to 256; pixel store is not cleared
// depends on bps_pkg, bps_addr, bps_store, bps_blend
module bilinear_pixel_sampler import bps_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  req_t                 req,
  output logic                 done,
  output res_t                 result,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [DIM_W-1:0]     cfg_data
);

  logic [DIM_W-1:0] image_width, image_height;
  logic [DIM_W-1:0] cfg_w_clamped, cfg_h_clamped;
  logic             accept;
  mem_ctl_t         ctl;
  blend_ctl_t       bctl;
  logic [NBANK-1:0][PIX_W-1:0] pix;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;
  assign accept    = start && !busy;

  always_comb begin
    cfg_w_clamped = cfg_data;
    if (cfg_data == '0) cfg_w_clamped = DIM_W'(1);
    else if (cfg_data > MAX_WIDTH) cfg_w_clamped = MAX_WIDTH;
    cfg_h_clamped = cfg_data;
    if (cfg_data == '0) cfg_h_clamped = DIM_W'(1);
    else if (cfg_data > MAX_HEIGHT) cfg_h_clamped = MAX_HEIGHT;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= MAX_WIDTH;
      image_height <= MAX_HEIGHT;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_WIDTH:  image_width  <= cfg_w_clamped;
        REG_HEIGHT: image_height <= cfg_h_clamped;
        default: ;
      endcase
    end
  end

  bps_addr u_addr (
    .clk, .rst, .accept, .req, .image_width, .image_height, .ctl
  );

  bps_store u_store (
    .clk, .rst, .ctl, .bctl, .pix
  );

  bps_blend u_blend (
    .clk, .rst, .bctl, .pix, .done, .result
  );

  a_done_follows_start: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(accept, 5))
    else $error("result without a matching request");

  a_write_zero_color: assert property (@(posedge clk) disable iff (rst)
    (done && (result.red_out != '0 || result.green_out != '0 || result.blue_out != '0))
      |-> result.ok)
    else $error("nonzero color on a rejected write");

  a_dims_nonzero: assert property (@(posedge clk) disable iff (rst)
    (image_width != '0) && (image_height != '0) && (image_width <= MAX_WIDTH)
      && (image_height <= MAX_HEIGHT))
    else $error("image size out of range");

endmodule

// ===== rtl/core/bps_addr.sv =====
// coordinate clamp and address generation, two register stages
// depends on bps_pkg
module bps_addr import bps_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              accept,
  input  req_t              req,
  input  logic [DIM_W-1:0]  image_width,
  input  logic [DIM_W-1:0]  image_height,
  output mem_ctl_t          ctl
);

  logic [INT_W-1:0] ix, iy, ix1_lo, iy1_lo;
  logic [DIM_W-1:0] ix1, iy1, wm1, hm1;

  // stage 0 registers
  logic                 v0, cmd0, landed0;
  logic [FRAC_BITS-1:0] fx0, fy0;
  logic [PIX_W-1:0]     color0;
  logic [INT_W-1:0]     c0, c1, r0, r1;

  logic [INT_W-1:0]     c0_next, c1_next, r0_next, r1_next;

  assign ix  = req.x_pos[COORD_W-1:FRAC_BITS];
  assign iy  = req.y_pos[COORD_W-1:FRAC_BITS];
  assign ix1 = {1'b0, ix} + DIM_W'(1);
  assign iy1 = {1'b0, iy} + DIM_W'(1);
  assign ix1_lo = ix1[INT_W-1:0];
  assign iy1_lo = iy1[INT_W-1:0];
  assign wm1 = image_width - DIM_W'(1);
  assign hm1 = image_height - DIM_W'(1);

  always_comb begin
    c0_next = ({1'b0, ix} < image_width)  ? ix     : wm1[INT_W-1:0];
    c1_next = (ix1 < image_width)         ? ix1_lo : wm1[INT_W-1:0];
    r0_next = ({1'b0, iy} < image_height) ? iy     : hm1[INT_W-1:0];
    r1_next = (iy1 < image_height)        ? iy1_lo : hm1[INT_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
    end else begin
      v0 <= accept;
    end
    cmd0    <= req.cmd;
    landed0 <= ({1'b0, ix} < image_width) && ({1'b0, iy} < image_height);
    fx0     <= req.x_pos[FRAC_BITS-1:0];
    fy0     <= req.y_pos[FRAC_BITS-1:0];
    color0  <= req.pixel_in;
    c0      <= c0_next;
    c1      <= c1_next;
    r0      <= r0_next;
    r1      <= r1_next;
  end

  // stage 1: row times width, one product per row
  logic [INT_W+DIM_W-1:0] row0_base, row1_base;
  assign row0_base = r0 * image_width;
  assign row1_base = r1 * image_width;

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl.valid <= 1'b0;
    end else begin
      ctl.valid <= v0;
    end
    ctl.cmd      <= cmd0;
    ctl.landed   <= landed0;
    ctl.fx       <= fx0;
    ctl.fy       <= fy0;
    ctl.color    <= color0;
    // a landed write has c0 equal to its own column, so bank TL carries the write address
    ctl.addr[TL] <= ADDR_W'(row0_base + (INT_W+DIM_W)'(c0));
    ctl.addr[TR] <= ADDR_W'(row0_base + (INT_W+DIM_W)'(c1));
    ctl.addr[BL] <= ADDR_W'(row1_base + (INT_W+DIM_W)'(c0));
    ctl.addr[BR] <= ADDR_W'(row1_base + (INT_W+DIM_W)'(c1));
  end

endmodule

// ===== rtl/core/bps_store.sv =====
// pixel store: four replicated banks, one read port each, shared write
// depends on bps_pkg
module bps_store import bps_pkg::*; (
  input  logic                        clk,
  input  logic                        rst,
  input  mem_ctl_t                    ctl,
  output blend_ctl_t                  bctl,
  output logic [NBANK-1:0][PIX_W-1:0] pix
);

  logic we;
  assign we = ctl.valid && (ctl.cmd == CMD_WRITE) && ctl.landed;

  for (genvar b = 0; b < NBANK; b++) begin : g_bank
    logic [PIX_W-1:0] mem [DEPTH];
    always_ff @(posedge clk) begin
      if (we) begin
        mem[ctl.addr[TL]] <= ctl.color;
      end
      pix[b] <= mem[ctl.addr[b]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bctl.valid <= 1'b0;
    end else begin
      bctl.valid <= ctl.valid;
    end
    bctl.cmd    <= ctl.cmd;
    bctl.landed <= ctl.landed;
    bctl.fx     <= ctl.fx;
    bctl.fy     <= ctl.fy;
  end

endmodule

// ===== rtl/core/bps_blend.sv =====
// horizontal then vertical blend per channel, two register stages
// depends on bps_pkg
module bps_blend import bps_pkg::*; (
  input  logic                        clk,
  input  logic                        rst,
  input  blend_ctl_t                  bctl,
  input  logic [NBANK-1:0][PIX_W-1:0] pix,
  output logic                        done,
  output res_t                        result
);

  logic                              v3, cmd3, landed3;
  logic [FRAC_BITS-1:0]              fy3;
  logic [2:0][CHAN_W-1:0]            top, bot;

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else begin
      v3 <= bctl.valid;
    end
    cmd3    <= bctl.cmd;
    landed3 <= bctl.landed;
    fy3     <= bctl.fy;
    for (int k = 0; k < 3; k++) begin
      top[k] <= lerp(pix[TL][k*CHAN_W +: CHAN_W], pix[TR][k*CHAN_W +: CHAN_W], bctl.fx);
      bot[k] <= lerp(pix[BL][k*CHAN_W +: CHAN_W], pix[BR][k*CHAN_W +: CHAN_W], bctl.fx);
    end
  end

  logic [2:0][CHAN_W-1:0] mix;
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      mix[k] = (cmd3 == CMD_SAMPLE) ? lerp(top[k], bot[k], fy3) : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= v3;
    end
    result.red_out   <= mix[2];
    result.green_out <= mix[1];
    result.blue_out  <= mix[0];
    result.ok        <= (cmd3 == CMD_SAMPLE) || landed3;
  end

endmodule
